// ===== hdl/cltim_pkg.sv =====
`timescale 1ns / 1ps

package cltim_pkg;

    // Operation codes carried in the request item
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Address regions
    localparam logic [1:0] REGION_NONE = 2'd0;
    localparam logic [1:0] REGION_SOFT = 2'd1;
    localparam logic [1:0] REGION_CMP  = 2'd2;
    localparam logic [1:0] REGION_TIME = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_HART_SELECT    = 2'd0;
    localparam logic [1:0] CFG_TICK_INCREMENT = 2'd1;

    localparam logic [15:0] COMPARE_BASE      = 16'h4000;
    localparam logic [15:0] TIME_OFFSET       = 16'hBFF8;
    localparam logic [63:0] COMPARE_RESET     = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SOFT_RESET        = 64'h0;
    localparam logic [31:0] INCREMENT_RESET   = 32'd7000;
    localparam logic [1:0]  HART_SELECT_RESET = 2'd0;

    localparam int HARTS_DEFAULT = 4;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] byte_offset;
        logic [63:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        timer_fire;
    } rsp_item_t;

endpackage

// ===== hdl/cltim_ram.sv =====
`timescale 1ns / 1ps

module cltim_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // read returns the old word on a same-cycle write
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cltim_decode.sv =====
`timescale 1ns / 1ps

module cltim_decode #(
    parameter int HARTS = 4,
    parameter int IDX_W = 2
) (
    input  logic [15:0]      byte_offset,
    output logic [1:0]       region,
    output logic [IDX_W-1:0] idx
);

    import cltim_pkg::*;

    localparam logic [15:0] SPAN    = 16'(HARTS * 8);
    localparam logic [15:0] CMP_END = 16'(32'(COMPARE_BASE) + HARTS * 8);

    logic [15:0] rel;
    logic        in_soft;
    logic        in_cmp;

    always_comb
    begin
        rel     = byte_offset - COMPARE_BASE;
        in_soft = byte_offset < SPAN;
        in_cmp  = (byte_offset >= COMPARE_BASE) && (byte_offset < CMP_END);
        if (in_soft)
        begin
            region = REGION_SOFT;
            idx    = byte_offset[IDX_W+2:3];
        end
        else if (in_cmp)
        begin
            region = REGION_CMP;
            idx    = rel[IDX_W+2:3];
        end
        else if (byte_offset == TIME_OFFSET)
        begin
            region = REGION_TIME;
            idx    = '0;
        end
        else
        begin
            region = REGION_NONE;
            idx    = '0;
        end
    end

endmodule

// ===== hdl/core_local_timer_interruptor_top.sv =====
`timescale 1ns / 1ps

// Core-local timer and interrupt register block. One request item (read, write or tick) is
// taken per cycle while req_stall is low; its result item is registered: acceptance loads
// the execute stage together with the RAM read, and the output register is loaded from the
// execute stage. Stalls from the result side back up through both stages to req_stall.
// Software-pending and compare words sit in two single-port-read RAMs of HARTS words each;
// one read per item (the addressed word, or the selected hart's compare word on a tick) sets
// the one-item-per-cycle figure, with a bypass of the write made in the same cycle. After
// reset a clearing pass loads zero into every pending word and all ones into every compare
// word; requests are stalled during it, configuration writes are taken at all times.
module core_local_timer_interruptor_top #(
    parameter int HARTS = cltim_pkg::HARTS_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  cltim_pkg::req_item_t req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output cltim_pkg::rsp_item_t rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    import cltim_pkg::*;

    localparam int IDX_W = (HARTS > 1) ? $clog2(HARTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HARTS - 1);

    // configuration
    logic [1:0]  hart_select_reg;
    logic [31:0] tick_increment_reg;

    // clearing pass
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_addr_reg;

    // execute stage
    logic             s1_valid_reg;
    logic [1:0]       s1_func_reg;
    logic [1:0]       s1_region_reg;
    logic [IDX_W-1:0] s1_addr_reg;
    logic [63:0]      s1_data_reg;

    // bypass of the RAM write made at the edge an item was read
    logic             fwd_soft_reg;
    logic             fwd_cmp_reg;
    logic [IDX_W-1:0] fwd_addr_reg;
    logic [63:0]      fwd_data_reg;

    logic [63:0] time_count_reg;
    logic [63:0] time_count_next;

    logic      out_valid_reg;
    rsp_item_t out_item_reg;
    rsp_item_t out_item_next;

    logic             accept;
    logic             out_free;
    logic             s1_go;
    logic [1:0]       dec_region;
    logic [IDX_W-1:0] dec_idx;
    logic [31:0]      hs_wide;
    logic             hart_ok;
    logic [IDX_W-1:0] hs_addr;
    logic [IDX_W-1:0] rd_addr;
    logic             s1_wr_soft;
    logic             s1_wr_cmp;
    logic             soft_we;
    logic             cmp_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [63:0]      soft_wdata;
    logic [63:0]      cmp_wdata;
    logic [63:0]      soft_rdata;
    logic [63:0]      cmp_rdata;
    logic [63:0]      soft_val;
    logic [63:0]      cmp_val;
    logic [63:0]      tick_sum;

    // configuration port never blocks
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hart_select_reg    <= HART_SELECT_RESET;
            tick_increment_reg <= INCREMENT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_HART_SELECT:    hart_select_reg    <= cfg_data[1:0];
                CFG_TICK_INCREMENT: tick_increment_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // handshake: the execute stage moves on whenever the output register is free
    assign out_free  = !out_valid_reg || !rsp_stall;
    assign s1_go     = s1_valid_reg && out_free;
    assign req_stall = clr_active_reg || (s1_valid_reg && !out_free);
    assign accept    = req_valid && !req_stall;

    cltim_decode #(
        .HARTS (HARTS),
        .IDX_W (IDX_W)
    ) u_decode (
        .byte_offset (req.byte_offset),
        .region      (dec_region),
        .idx         (dec_idx)
    );

    // selected hart; an absent hart reads entry zero and never fires
    assign hs_wide = {30'd0, hart_select_reg};
    assign hart_ok = hs_wide < 32'(HARTS);
    assign hs_addr = hart_ok ? hs_wide[IDX_W-1:0] : '0;
    assign rd_addr = (req.func == FUNC_TICK) ? hs_addr : dec_idx;

    // RAM writes: clearing pass first, then writes leaving the execute stage
    assign s1_wr_soft = s1_go && (s1_func_reg == FUNC_WRITE) && (s1_region_reg == REGION_SOFT);
    assign s1_wr_cmp  = s1_go && (s1_func_reg == FUNC_WRITE) && (s1_region_reg == REGION_CMP);
    assign soft_we    = clr_active_reg || s1_wr_soft;
    assign cmp_we     = clr_active_reg || s1_wr_cmp;
    assign ram_waddr  = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign soft_wdata = clr_active_reg ? SOFT_RESET : s1_data_reg;
    assign cmp_wdata  = clr_active_reg ? COMPARE_RESET : s1_data_reg;

    cltim_ram #(
        .WIDTH (64),
        .DEPTH (HARTS)
    ) u_soft_ram (
        .clk   (clk),
        .we    (soft_we),
        .waddr (ram_waddr),
        .wdata (soft_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (soft_rdata)
    );

    cltim_ram #(
        .WIDTH (64),
        .DEPTH (HARTS)
    ) u_cmp_ram (
        .clk   (clk),
        .we    (cmp_we),
        .waddr (ram_waddr),
        .wdata (cmp_wdata),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (cmp_rdata)
    );

    // advance the clearing pass one entry a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_addr_reg == LAST_IDX)
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // load the execute stage; capture the write that coincides with the RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_soft_reg <= 1'b0;
            fwd_cmp_reg  <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            fwd_soft_reg <= s1_wr_soft;
            fwd_cmp_reg  <= s1_wr_cmp;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= req.func;
            s1_region_reg <= dec_region;
            s1_addr_reg   <= rd_addr;
            s1_data_reg   <= req.write_data;
            fwd_addr_reg  <= s1_addr_reg;
            fwd_data_reg  <= s1_data_reg;
        end
    end

    // execute: bypass, select, add and compare
    always_comb
    begin
        soft_val = (fwd_soft_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : soft_rdata;
        cmp_val  = (fwd_cmp_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : cmp_rdata;
        tick_sum = time_count_reg + {32'd0, tick_increment_reg};

        time_count_next = time_count_reg;
        out_item_next   = '0;
        case (s1_func_reg)
            FUNC_READ:
            begin
                case (s1_region_reg)
                    REGION_SOFT: out_item_next.read_data = soft_val;
                    REGION_CMP:  out_item_next.read_data = cmp_val;
                    REGION_TIME: out_item_next.read_data = time_count_reg;
                    default:     out_item_next.read_data = '0;
                endcase
            end
            FUNC_WRITE:
            begin
                if (s1_region_reg == REGION_TIME)
                begin
                    time_count_next = s1_data_reg;
                end
            end
            FUNC_TICK:
            begin
                time_count_next          = tick_sum;
                out_item_next.timer_fire = hart_ok && (tick_sum >= cmp_val);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_count_reg <= '0;
        end
        else if (s1_go)
        begin
            time_count_reg <= time_count_next;
        end
    end

    // output register: hold while stalled, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            out_item_reg <= out_item_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;

`ifndef SYNTHESIS
    // no item may sit in the execute stage while the RAMs are being cleared
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !s1_valid_reg)
        else $error("item in execute stage during clearing pass");

    // an accepted item lands in the execute stage
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted item lost");

    // only a tick can raise timer_fire
    a_fire_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_go && (s1_func_reg != FUNC_TICK)) |=> !rsp.timer_fire)
        else $error("timer_fire on a non-tick item");
`endif

endmodule
